// ===== sv/urid_pkg.sv =====
package urid_pkg;

  // Character codes
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  // Line-break modes for decoded CR and LF
  localparam logic [1:0] LbKeep = 2'd0;
  localparam logic [1:0] LbLf   = 2'd1;
  localparam logic [1:0] LbCrlf = 2'd2;
  localparam logic [1:0] LbCr   = 2'd3;

  // Register index of line_break_mode
  localparam logic RegLineBreakMode = 1'b0;

  // Up to three result items caused by one input item
  typedef struct packed {
    logic [2:0][7:0] chars;   // chars[0] goes out first
    logic [1:0]      cnt;     // number of result items, 0 to 3
    logic            last;    // final item of the group carries tlast
    logic            marker;  // single end-only item without a character
  } res_grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ===== sv/urid_esc.sv =====
module urid_esc import urid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  logic [1:0] mode_i,
  input  logic       take_i,
  output res_grp_t   grp_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhPct  = 2'd1;
  localparam logic [1:0] PhHex  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       cr_q, cr_d;

  logic            hex;
  logic [7:0]      code;
  logic            plain;
  logic [1:0]      n;
  logic [2:0][7:0] chars;
  logic            marker;

  assign hex  = is_hex(char_i);
  assign code = {hex_val(held_q), hex_val(char_i)};

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    cr_d    = cr_q;
    plain   = 1'b0;
    n       = 2'd0;
    chars   = '0;
    marker  = 1'b0;

    unique case (phase_q)
      PhPct: begin
        if (hex) begin
          phase_d = PhHex;
          held_d  = char_i;
        end else begin
          chars[n] = CharPct;
          n        = n + 2'd1;
          cr_d     = 1'b0;
          phase_d  = PhIdle;
          plain    = 1'b1;
        end
      end
      PhHex: begin
        phase_d = PhIdle;
        if (hex) begin
          if (code == CharLf) begin
            if (mode_i == LbKeep) begin
              chars[n] = CharLf;
              n        = n + 2'd1;
            end else if (!cr_q) begin
              if (mode_i == LbLf) begin
                chars[n] = CharLf;
                n        = n + 2'd1;
              end else if (mode_i == LbCrlf) begin
                chars[n] = CharCr;
                n        = n + 2'd1;
                chars[n] = CharLf;
                n        = n + 2'd1;
              end else begin
                chars[n] = CharCr;
                n        = n + 2'd1;
              end
            end
            cr_d = 1'b0;
          end else if (code == CharCr) begin
            if (mode_i == LbLf) begin
              chars[n] = CharLf;
              n        = n + 2'd1;
            end else if (mode_i == LbCrlf) begin
              chars[n] = CharCr;
              n        = n + 2'd1;
              chars[n] = CharLf;
              n        = n + 2'd1;
            end else begin
              chars[n] = CharCr;
              n        = n + 2'd1;
            end
            cr_d = 1'b1;
          end else begin
            chars[n] = code;
            n        = n + 2'd1;
            cr_d     = 1'b0;
          end
        end else begin
          // broken escape: hand back the percent sign and the held digit
          chars[n] = CharPct;
          n        = n + 2'd1;
          chars[n] = held_q;
          n        = n + 2'd1;
          cr_d     = 1'b0;
          plain    = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      if (char_i == CharPct) begin
        phase_d = PhPct;
      end else begin
        chars[n] = (char_i == CharPlus) ? CharSpace : char_i;
        n        = n + 2'd1;
        cr_d     = 1'b0;
      end
    end

    if (last_i) begin
      // flush a pending escape as literal text
      if (phase_d == PhPct) begin
        chars[n] = CharPct;
        n        = n + 2'd1;
      end else if (phase_d == PhHex) begin
        chars[n] = CharPct;
        n        = n + 2'd1;
        chars[n] = held_d;
        n        = n + 2'd1;
      end
      if (n == 2'd0) begin
        marker = 1'b1;
        n      = 2'd1;
      end
      phase_d = PhIdle;
      held_d  = 8'h00;
      cr_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
      cr_q    <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      cr_q    <= cr_d;
    end
  end

  assign grp_o.chars  = chars;
  assign grp_o.cnt    = n;
  assign grp_o.last   = last_i;
  assign grp_o.marker = marker;

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle || phase_q == PhPct || phase_q == PhHex))
    else $error("escape phase holds an unused code");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && last_i) |=> (phase_q == PhIdle && !cr_q && held_q == 8'h00))
    else $error("escape state not cleared after end of text");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && last_i) |-> (n != 2'd0))
    else $error("end of text produced no result item");

endmodule

// ===== sv/urid_obuf.sv =====
module urid_obuf import urid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_grp_t   grp_i,
  input  logic       load_i,
  output logic       ready_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tuser_o,   // [0] char_valid
  output logic       m_axis_tlast_o    // out_last
);

  logic [2:0][7:0] ch_q;
  logic [1:0]      cnt_q;
  logic            last_q;
  logic            mk_q;
  logic            pop;
  logic            fill;

  assign pop     = (cnt_q != 2'd0) && m_axis_tready_i;
  assign ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready_i);
  assign fill    = load_i && (grp_i.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      last_q <= 1'b0;
      mk_q   <= 1'b0;
    end else if (fill) begin
      cnt_q  <= grp_i.cnt;
      last_q <= grp_i.last;
      mk_q   <= grp_i.marker;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // shift the next character down as each item leaves
  always_ff @(posedge clk_i) begin
    if (fill) begin
      ch_q <= grp_i.chars;
    end else if (pop) begin
      ch_q[0] <= ch_q[1];
      ch_q[1] <= ch_q[2];
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = mk_q ? 8'h00 : ch_q[0];
  assign m_axis_tuser_o  = !mk_q;
  assign m_axis_tlast_o  = last_q && (cnt_q == 2'd1);

  a_fill_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("result group loaded over pending items");

  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0 && mk_q) |-> (cnt_q == 2'd1 && last_q))
    else $error("end-only item not alone or not last");

endmodule

// ===== sv/uri_percent_decoder.sv =====
// URI percent decoder: one text character in per item, zero to three characters out.
// An accepted item waits in the input register until the result register can take its
// group. Throughput: one item per cycle while each item yields at most one result and
// m_axis_tready is high; a multi-result item holds the result register until all leave.
// Reset (rst_ni low, asynchronous): no item held, no escape pending, line-break mode 0.
module uri_percent_decoder import urid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input text
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // in_last
  // decoded text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tuser,   // [0] char_valid
  output logic        m_axis_tlast    // out_last
);

  logic [1:0] mode_q;
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       obuf_ready;
  logic       adv;
  logic       s_acc;
  res_grp_t   grp;

  // Register file: one register, line_break_mode at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLineBreakMode) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LbKeep;
    end else if (psel && penable && pwrite && paddr[2] == RegLineBreakMode) begin
      mode_q <= pwdata[1:0];
    end
  end

  // Input register: advance into the decoder whenever the output side can
  // take the whole result group of the held item.
  assign adv           = in_vld_q && obuf_ready;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Escape tracking and line-break rewrite for the held item.
  urid_esc u_esc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .mode_i (mode_q),
    .take_i (adv),
    .grp_o  (grp)
  );

  // Result register: hold the group and hand out one item per cycle while m_axis_tready is high.
  urid_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grp_i           (grp),
    .load_i          (adv),
    .ready_o         (obuf_ready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_char_q) && $stable(in_last_q)))
    else $error("held input item lost or changed while stalled");

endmodule
